>>> design/qkm_pkg.sv
// Shared types, constants and the piano-row lookup for the key to note mapper.
package qkm_pkg;

   localparam int KEY_SLOTS       = 96;
   localparam int SLOT_W          = $clog2(KEY_SLOTS);
   localparam int CODE_W          = 7;
   localparam int NOTE_W          = 7;
   localparam int VEL_W           = 7;
   localparam int OCT_W           = 4;
   localparam int TRANS_W         = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 7;
   localparam int SUM_W           = 9;

   localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 7'd32;
   localparam logic [NOTE_W-1:0] NOTE_NONE       = 7'd0;
   localparam logic [NOTE_W-1:0] NOTE_MIN        = 7'd1;
   localparam logic [NOTE_W-1:0] NOTE_MAX        = 7'd127;
   localparam logic [VEL_W-1:0]  VEL_RESET       = 7'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCTAVE    = 2'd0,
      CSR_TRANSPOSE = 2'd1,
      CSR_VELOCITY  = 2'd2
   } qkm_csr_idx_type;

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic              key_release;
   } qkm_req_type;

   typedef struct packed {
      logic              note_on;
      logic [NOTE_W-1:0] note_number;
      logic [VEL_W-1:0]  velocity;
   } qkm_rsp_type;

   typedef struct packed {
      logic signed [OCT_W-1:0]   octave_shift;
      logic signed [TRANS_W-1:0] transpose_semitones;
      logic [VEL_W-1:0]          note_velocity;
   } qkm_cfg_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [NOTE_W-1:0] note;
   } qkm_store_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } qkm_store_rd_type;

   // Home row piano layout; every other key maps to 0.
   function automatic logic [NOTE_W-1:0] piano_row(input logic [CODE_W-1:0] code);
      logic [NOTE_W-1:0] n;
      unique case (code)
         7'h61:   n = 7'd60; // a
         7'h77:   n = 7'd61; // w
         7'h73:   n = 7'd62; // s
         7'h65:   n = 7'd63; // e
         7'h64:   n = 7'd64; // d
         7'h66:   n = 7'd65; // f
         7'h74:   n = 7'd66; // t
         7'h67:   n = 7'd67; // g
         7'h79:   n = 7'd68; // y
         7'h68:   n = 7'd69; // h
         7'h75:   n = 7'd70; // u
         7'h6a:   n = 7'd71; // j
         7'h6b:   n = 7'd72; // k
         7'h6f:   n = 7'd73; // o
         7'h6c:   n = 7'd74; // l
         7'h70:   n = 7'd75; // p
         7'h3b:   n = 7'd76; // ;
         7'h27:   n = 7'd77; // '
         default: n = NOTE_NONE;
      endcase
      return n;
   endfunction

endpackage

>>> design/qkm_csr.sv
// Configuration registers: octave shift, transpose and velocity.
module qkm_csr
   import qkm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output qkm_cfg_type           cfg
);

   qkm_cfg_type cfg_ff;
   qkm_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OCTAVE:    cfg_in.octave_shift        = csr_data[OCT_W-1:0];
            CSR_TRANSPOSE: cfg_in.transpose_semitones = csr_data[TRANS_W-1:0];
            CSR_VELOCITY:  cfg_in.note_velocity       = csr_data[VEL_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octave_shift        <= '0;
         cfg_ff.transpose_semitones <= '0;
         cfg_ff.note_velocity       <= VEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/qkm_note_calc.sv
// Piano-row lookup, octave and transpose offset, and clamp to 1..127.
module qkm_note_calc
   import qkm_pkg::*;
(
   input  logic [CODE_W-1:0] key_code,
   input  qkm_cfg_type       cfg,
   output logic [NOTE_W-1:0] note
);

   logic signed [SUM_W-1:0] raw;
   logic signed [SUM_W-1:0] oct;
   logic signed [SUM_W-1:0] oct12;
   logic signed [SUM_W-1:0] trans;
   logic signed [SUM_W-1:0] sum;

   always_comb begin
      raw   = $signed({{(SUM_W-NOTE_W){1'b0}}, piano_row(key_code)});
      oct   = $signed({{(SUM_W-OCT_W){cfg.octave_shift[OCT_W-1]}}, cfg.octave_shift});
      oct12 = (oct <<< 3) + (oct <<< 2);
      trans = $signed({{(SUM_W-TRANS_W){cfg.transpose_semitones[TRANS_W-1]}},
                       cfg.transpose_semitones});
      sum   = raw + oct12 + trans;
      priority if (sum < $signed({2'b00, NOTE_MIN})) begin
         note = NOTE_MIN;
      end else if (sum > $signed({2'b00, NOTE_MAX})) begin
         note = NOTE_MAX;
      end else begin
         note = sum[NOTE_W-1:0];
      end
   end

endmodule

>>> design/qkm_held_store.sv
// Held-note memory per key slot with per-entry valid bits and write forwarding.
module qkm_held_store
   import qkm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  qkm_store_rd_type  rd,
   input  qkm_store_wr_type  wr,
   output logic [NOTE_W-1:0] held_note
);

   logic [NOTE_W-1:0]    mem [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] vld_ff;
   logic [NOTE_W-1:0]    rd_data_ff;
   logic                 rd_vld_ff;
   logic                 fwd_ff;
   logic [NOTE_W-1:0]    fwd_note_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.slot] <= wr.note;
      end
      if (rd.en) begin
         rd_data_ff  <= mem[rd.slot];
         rd_vld_ff   <= vld_ff[rd.slot];
         fwd_note_ff <= wr.note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         fwd_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.slot] <= 1'b1;
         end
         // same-slot write in the read cycle: the array still returns the old entry
         if (rd.en) begin
            fwd_ff <= wr.en && (wr.slot == rd.slot);
         end
      end
   end

   assign held_note = fwd_ff    ? fwd_note_ff :
                      rd_vld_ff ? rd_data_ff  : NOTE_NONE;

endmodule

>>> design/qwerty_key_to_midi_note.sv
// Top level of the QWERTY key to MIDI note mapper.
//
// Usage:
//   req_*  : key events (ASCII code, press/release), valid/stall handshake.
//   rsp_*  : at most one note message per request (note-on/off, number, velocity).
//   csr_*  : register writes (0 octave, 1 transpose, 2 velocity); csr_ready is
//            always high, so a write lands on any cycle with csr_valid.
// Pipeline: two register stages, request register then result register; the
//   message is formed from the request register and held in the result register.
// Throughput: one request per cycle unless req_stall is high; held notes are read
//   at capture, written back as the request advances, with same-key forwarding.
// Requests that give no message (control codes, press of a held key) pass
//   through without a bubble on the result side.
// Reset: synchronous, active high; all keys hold no note, octave and transpose
//   are 0, velocity is 100.
// Stall: a stalled result holds in the output register; one more request is
//   still taken into the request register, and if it gives a message req_stall
//   rises until the result is taken.
module qwerty_key_to_midi_note
   import qkm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  qkm_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output qkm_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   qkm_cfg_type      cfg;
   qkm_store_rd_type store_rd;
   qkm_store_wr_type store_wr;
   logic [NOTE_W-1:0] held_note;
   logic [NOTE_W-1:0] press_note;

   qkm_req_type       s1_ff;
   logic              s1_vld_ff;
   logic [SLOT_W-1:0] s1_slot;
   logic              s1_printable;
   logic              s1_emit;
   logic              s1_go;
   logic              out_free;
   logic              req_take;
   logic              req_printable;
   logic [CODE_W-1:0] req_slot_full;
   logic [CODE_W-1:0] s1_slot_full;

   qkm_rsp_type rsp_ff;
   qkm_rsp_type rsp_in;
   logic        rsp_vld_ff;

   qkm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qkm_held_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd        (store_rd),
      .wr        (store_wr),
      .held_note (held_note)
   );

   qkm_note_calc u_calc (
      .key_code (s1_ff.key_code),
      .cfg      (cfg),
      .note     (press_note)
   );

   // handshake between the request register and the result register
   always_comb begin
      out_free  = !rsp_vld_ff || !rsp_stall;
      s1_go     = s1_vld_ff && (out_free || !s1_emit);
      req_stall = s1_vld_ff && !s1_go;
      req_take  = req_valid && !req_stall;
   end

   always_comb begin
      req_printable = req_data.key_code >= FIRST_PRINTABLE;
      req_slot_full = req_data.key_code - FIRST_PRINTABLE;
      store_rd.en   = req_take;
      store_rd.slot = req_printable ? req_slot_full[SLOT_W-1:0] : '0;
   end

   always_comb begin
      s1_printable = s1_ff.key_code >= FIRST_PRINTABLE;
      s1_slot_full = s1_ff.key_code - FIRST_PRINTABLE;
      s1_slot      = s1_slot_full[SLOT_W-1:0];
      // press of a held key is a restrike: no message, no write
      s1_emit      = s1_vld_ff && s1_printable &&
                     (s1_ff.key_release || (held_note == NOTE_NONE));

      store_wr.en   = s1_go && s1_emit;
      store_wr.slot = s1_slot;
      store_wr.note = s1_ff.key_release ? NOTE_NONE : press_note;

      rsp_in.note_on     = !s1_ff.key_release;
      rsp_in.note_number = s1_ff.key_release ? held_note : press_note;
      rsp_in.velocity    = cfg.note_velocity;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_data;
      end
      if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_take || s1_go) begin
            s1_vld_ff <= req_take;
         end
         if (out_free) begin
            rsp_vld_ff <= s1_emit;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_vld_ff && rsp_stall))
      else $error("request stalled without a blocked result");

   a_note_on_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.note_on) |-> (rsp_data.note_number != NOTE_NONE))
      else $error("note-on with note number zero");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (s1_vld_ff && s1_printable && out_free))
      else $error("held-note write without the item advancing");

endmodule

>>> tb/tb.sv
// Testbench for the key to note mapper: directed table, then random checked key events.
module tb;
   import qkm_pkg::*;

   localparam logic MSG_ON    = 1'b1;
   localparam logic MSG_OFF   = 1'b0;
   localparam logic KEY_PRESS = 1'b0;
   localparam logic KEY_UP    = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int   PLAN_ROWS   = 33;
   localparam int   PHASES      = 8;
   localparam int   PHASE_KEYS  = 175;
   localparam int   HOLD_CYCLES = 80;
   localparam int   SETTLE      = 4;
   localparam int   STUCK_LIMIT = 2000;

   typedef enum logic {ROW_KEY, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;
      logic [CODE_W-1:0]     code;
      logic                  up;
      logic                  typed;
      logic                  made;
      logic                  on;
      logic [NOTE_W-1:0]     note;
      logic [VEL_W-1:0]      vel;
   } plan_row_type;

   // Expected message typed in only where it is obvious; other rows use the predictor.
   plan_row_type key_plan [PLAN_ROWS] = '{
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h00, KEY_PRESS, 1'b1, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h1f, KEY_UP, 1'b1, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd60, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_PRESS, 1'b1, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd60, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd0, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h27, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd77, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h3b, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd76, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h20, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd1, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h7f, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd1, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h7f, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd1, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h20, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd1, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h27, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd77, 7'd100},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h3b, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd76, 7'd100},
      '{ROW_CSR, CSR_OCTAVE, 7'h07, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_TRANSPOSE, 7'h0f, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_VELOCITY, 7'h7f, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h6b, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd127, 7'd127},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h6b, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd127, 7'd127},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h6b, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_OCTAVE, 7'h08, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_TRANSPOSE, 7'h10, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_VELOCITY, 7'h00, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h6b, KEY_UP, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_PRESS, 1'b1, 1'b1, MSG_ON, 7'd1, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h61, KEY_UP, 1'b1, 1'b1, MSG_OFF, 7'd1, 7'd0},
      '{ROW_CSR, CSR_SPARE, 7'h7f, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_OCTAVE, 7'h7f, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_CSR, CSR_TRANSPOSE, 7'h03, 7'h00, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h77, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h77, KEY_UP, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h27, KEY_PRESS, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0},
      '{ROW_KEY, CSR_OCTAVE, 7'd0, 7'h27, KEY_UP, 1'b0, 1'b0, MSG_OFF, 7'd0, 7'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   qkm_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   qkm_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Typed expectation travelling alongside the request it belongs to.
   logic        fixed_row = 1'b0;
   logic        fixed_made = 1'b0;
   qkm_rsp_type fixed_msg = '0;

   logic signed [OCT_W-1:0]   model_octave = '0;
   logic signed [TRANS_W-1:0] model_transpose = '0;
   logic [VEL_W-1:0]          model_velocity = VEL_RESET;
   logic [NOTE_W-1:0]         held_note [KEY_SLOTS] = '{default: NOTE_NONE};

   qkm_rsp_type pending_notes [$];
   int          errors = 0;
   int          stuck_cycles = 0;
   logic        quiet = 1'b0;
   logic        hold_off_go = 1'b0;

   qwerty_key_to_midi_note u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int row_pitch(input logic [CODE_W-1:0] code);
      string keys;
      keys = "awsedftgyhujkolp;'";
      for (int i = 0; i < keys.len(); i++) begin
         if (code == keys[i]) return 60 + i;
      end
      return 0;
   endfunction

   function automatic void next_note(input qkm_req_type req, output logic made,
                                     output qkm_rsp_type msg);
      int slot;
      int pitch;
      made = 1'b0;
      msg  = '0;
      if (req.key_code < FIRST_PRINTABLE) return;
      slot = int'(req.key_code) - int'(FIRST_PRINTABLE);
      if (req.key_release == KEY_PRESS) begin
         if (held_note[slot] != NOTE_NONE) return;
         pitch = row_pitch(req.key_code) + 12 * int'(model_octave) + int'(model_transpose);
         if (pitch < 1) pitch = 1;
         if (pitch > 127) pitch = 127;
         held_note[slot] = pitch[NOTE_W-1:0];
         msg.note_on     = MSG_ON;
         msg.note_number = pitch[NOTE_W-1:0];
      end else begin
         msg.note_on     = MSG_OFF;
         msg.note_number = held_note[slot];
         held_note[slot] = NOTE_NONE;
      end
      msg.velocity = model_velocity;
      made = 1'b1;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_OCTAVE:    model_octave = value[OCT_W-1:0];
         CSR_TRANSPOSE: model_transpose = value[TRANS_W-1:0];
         CSR_VELOCITY:  model_velocity = value[VEL_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      logic        made;
      logic        moved;
      qkm_rsp_type want;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_notes.size() == 0) begin
               errors++;
               $display("%0t: note message with none expected, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = pending_notes.pop_front();
               check_field("note_on", int'(want.note_on), int'(rsp_data.note_on));
               check_field("note_number", int'(want.note_number),
                           int'(rsp_data.note_number));
               check_field("velocity", int'(want.velocity), int'(rsp_data.velocity));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            next_note(req_data, made, want);
            if (fixed_row) begin
               made = fixed_made;
               want = fixed_msg;
            end
            if (made) pending_notes.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            apply_csr(csr_index, csr_data);
         end
         if (moved) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("** qwerty_key_to_midi_note: FAILED **");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request.
   initial begin : rsp_side
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_key(input logic [CODE_W-1:0] code, input logic up, input logic typed,
                           input logic made, input qkm_rsp_type msg);
      csr_valid <= 1'b0;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.key_code    <= code;
      req_data.key_release <= up;
      fixed_row            <= typed;
      fixed_made           <= made;
      fixed_msg            <= msg;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stop offering and wait until every expected note message is in.
   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (pending_notes.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      int                    counted;
      int                    sel;
      logic [CODE_W-1:0]     code;
      logic [CSR_DATA_W-1:0] value;
      string                 keys;
      qkm_rsp_type           msg;
      keys = "awsedftgyhujkolp;'";
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (key_plan[i].kind == ROW_CSR) begin
            if (i == 0 || key_plan[i-1].kind != ROW_CSR) drain();
            write_reg(key_plan[i].idx, key_plan[i].value);
         end else begin
            msg.note_on     = key_plan[i].on;
            msg.note_number = key_plan[i].note;
            msg.velocity    = key_plan[i].vel;
            send_key(key_plan[i].code, key_plan[i].up, key_plan[i].typed,
                     key_plan[i].made, msg);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         quiet = (phase == PHASES - 1);
         // odd phases sweep the full register encodings, even phases stay musical
         if (phase % 2 == 1) begin
            write_reg(CSR_OCTAVE, 7'($urandom_range(0, 127)));
            write_reg(CSR_TRANSPOSE, 7'($urandom_range(0, 127)));
            write_reg(CSR_VELOCITY, 7'($urandom_range(0, 127)));
         end else begin
            value = 7'($urandom_range(0, 8) - 4);
            value[6:4] = 3'($urandom_range(0, 7));
            write_reg(CSR_OCTAVE, value);
            value = 7'($urandom_range(0, 22) - 11);
            value[6:5] = 2'($urandom_range(0, 3));
            write_reg(CSR_TRANSPOSE, value);
            write_reg(CSR_VELOCITY, 7'($urandom_range(1, 127)));
         end
         if (phase == 2) hold_off_go = 1'b1;
         counted = 0;
         while (counted < PHASE_KEYS) begin
            if (phase == 4 && counted == PHASE_KEYS / 2) drain();
            sel = $urandom_range(0, 9);
            if (sel < 7) code = 7'(keys[$urandom_range(0, keys.len() - 1)]);
            else if (sel < 9) code = 7'($urandom_range(32, 127));
            else code = 7'($urandom_range(0, 127));
            send_key(code, 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
            if (code >= FIRST_PRINTABLE) counted++;
         end
      end

      drain();
      if (errors == 0 && pending_notes.size() == 0) begin
         $display("** qwerty_key_to_midi_note: PASSED **");
      end else begin
         $display("** qwerty_key_to_midi_note: FAILED **");
      end
      $finish;
   end

endmodule

>>> qwerty_key_to_midi_note.f
design/qkm_pkg.sv
design/qkm_csr.sv
design/qkm_note_calc.sv
design/qkm_held_store.sv
design/qwerty_key_to_midi_note.sv
tb/tb.sv
